### src/bf3_pkg.sv
// ----------------------------------------------------------------------------
// bf3_pkg: shared types and constants of the 3x3 box filter
// Widths, pixel payload structs, command and register codes, and the
// reciprocal used for the divide by nine.
// ----------------------------------------------------------------------------
package bf3_pkg;

  localparam int MAX_WIDTH   = 2048;
  localparam int MAX_HEIGHT  = 4096;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int WIDTH_W     = 12;
  localparam int HEIGHT_W    = 13;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 13;
  localparam int PEND_W      = $clog2(MAX_WIDTH + 2);

  localparam int NUM_LANES   = 3;
  localparam int CHAN_W      = 8;
  localparam int LANE_BLUE   = 0;
  localparam int LANE_GREEN  = 1;
  localparam int LANE_RED    = 2;

  // Nine bytes plus the rounding bias fit in 12 bits.
  localparam int SUM_W       = 12;
  localparam int RECIP_W     = 13;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam int RECIP_SHIFT = 16;
  // ceil(2^16 / 9); exact quotient for every sum below 2^15
  localparam logic [RECIP_W-1:0] RECIP_NINE = 13'd7282;
  localparam logic [SUM_W-1:0]   ROUND_BIAS = 12'd4;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = 12'd3;
  localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = 13'd3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } command_t;

  typedef logic [NUM_LANES-1:0][CHAN_W-1:0] bgr_t;

  typedef struct packed {
    command_t          command;
    logic [CHAN_W-1:0] blue_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] red_in;
  } pixel_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] blue_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] red_out;
    logic              frame_end;
  } pixel_out_t;

  // Decision for one transfer, from the position counters to the datapath.
  typedef struct packed {
    logic             valid;
    logic             pixel;
    logic             emit;
    logic             interior;
    logic             frame_end;
    logic             use_mid;
    logic [COL_W-1:0] rd_addr;
    logic [COL_W-1:0] ctr_addr;
    logic [COL_W-1:0] wr_addr;
  } ctrl_t;

  // Side information that travels next to the lane pipelines.
  typedef struct packed {
    logic emit;
    logic interior;
    logic frame_end;
    bgr_t pass;
  } tag_t;

endpackage

### src/bf3_ctrl.sv
// ----------------------------------------------------------------------------
// bf3_ctrl: frame geometry, position counters and pending count
// Decides for each transfer what is read, written and emitted.
// ----------------------------------------------------------------------------
module bf3_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write_en,
  input  logic [bf3_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bf3_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             take,
  input  bf3_pkg::command_t                command,
  output bf3_pkg::ctrl_t                   ctrl
);
  import bf3_pkg::*;

  logic [WIDTH_W-1:0]  frame_width;
  logic [HEIGHT_W-1:0] frame_height;
  logic [COL_W-1:0]    in_column, in_column_next;
  logic [ROW_W-1:0]    in_row, in_row_next;
  logic [COL_W-1:0]    out_column, out_column_next;
  logic [ROW_W-1:0]    out_row, out_row_next;
  logic [PEND_W-1:0]   pending, pending_next;

  logic [WIDTH_W-1:0]  w;
  logic [HEIGHT_W-1:0] h;
  logic [PEND_W-1:0]   depth;
  logic                is_flush, at_start, flush_ok, restart, fire, wrap;
  logic [PEND_W-1:0]   pend_a;
  logic [COL_W-1:0]    oc_a, oc_e, oc_adv, ic_adv;
  logic [ROW_W-1:0]    or_a, or_e, or_adv, ir_adv;
  logic [WIDTH_W-1:0]  col_inc, in_col_inc;
  logic [HEIGHT_W-1:0] row_inc, in_row_inc;

  // Clamp the geometry registers to the supported range.
  always_comb begin
    if (frame_width < WIDTH_MIN) begin
      w = WIDTH_MIN;
    end else if (frame_width > WIDTH_W'(MAX_WIDTH)) begin
      w = WIDTH_W'(MAX_WIDTH);
    end else begin
      w = frame_width;
    end
    if (frame_height < HEIGHT_MIN) begin
      h = HEIGHT_MIN;
    end else if (frame_height > HEIGHT_W'(MAX_HEIGHT)) begin
      h = HEIGHT_W'(MAX_HEIGHT);
    end else begin
      h = frame_height;
    end
  end

  assign depth    = PEND_W'(w) + PEND_W'(1);
  assign is_flush = (command == CMD_FLUSH);
  assign at_start = (in_row == '0) && (in_column == '0);
  assign flush_ok = at_start && (pending != '0);
  assign restart  = at_start && (pending != '0) && (pending < depth);

  // Drop a partly drained frame when a new one starts.
  assign pend_a = restart ? '0 : pending;
  assign oc_a   = restart ? '0 : out_column;
  assign or_a   = restart ? '0 : out_row;
  assign fire   = (pend_a >= depth);
  assign wrap   = (WIDTH_W'(oc_a) >= w) || (HEIGHT_W'(or_a) >= h);

  always_comb begin
    if (is_flush) begin
      oc_e = out_column;
      or_e = out_row;
    end else if (wrap) begin
      oc_e = '0;
      or_e = '0;
    end else begin
      oc_e = oc_a;
      or_e = or_a;
    end
  end

  // Advance the output position.
  assign col_inc = WIDTH_W'(oc_e) + WIDTH_W'(1);
  assign row_inc = HEIGHT_W'(or_e) + HEIGHT_W'(1);
  always_comb begin
    if (col_inc >= w) begin
      oc_adv = '0;
      or_adv = (row_inc >= h) ? '0 : row_inc[ROW_W-1:0];
    end else begin
      oc_adv = col_inc[COL_W-1:0];
      or_adv = or_e;
    end
  end

  // Advance the input position.
  assign in_col_inc = WIDTH_W'(in_column) + WIDTH_W'(1);
  assign in_row_inc = HEIGHT_W'(in_row) + HEIGHT_W'(1);
  always_comb begin
    if (in_col_inc >= w) begin
      ic_adv = '0;
      ir_adv = (in_row_inc >= h) ? '0 : in_row_inc[ROW_W-1:0];
    end else begin
      ic_adv = in_col_inc[COL_W-1:0];
      ir_adv = in_row;
    end
  end

  always_comb begin
    in_column_next  = in_column;
    in_row_next     = in_row;
    out_column_next = out_column;
    out_row_next    = out_row;
    pending_next    = pending;
    if (take) begin
      if (is_flush) begin
        if (flush_ok) begin
          pending_next    = pending - PEND_W'(1);
          out_column_next = oc_adv;
          out_row_next    = or_adv;
        end
      end else begin
        in_column_next = ic_adv;
        in_row_next    = ir_adv;
        if (fire) begin
          pending_next    = depth;
          out_column_next = oc_adv;
          out_row_next    = or_adv;
        end else begin
          pending_next    = pend_a + PEND_W'(1);
          out_column_next = oc_a;
          out_row_next    = or_a;
        end
      end
    end
  end

  always_comb begin
    ctrl.valid     = is_flush ? flush_ok : 1'b1;
    ctrl.pixel     = !is_flush;
    ctrl.emit      = is_flush ? flush_ok : fire;
    ctrl.interior  = !is_flush && (or_e != '0) && (oc_e != '0)
                     && (HEIGHT_W'(or_e) + HEIGHT_W'(2) <= h)
                     && (WIDTH_W'(oc_e) + WIDTH_W'(2) <= w);
    ctrl.frame_end = (HEIGHT_W'(or_e) == h - HEIGHT_W'(1))
                     && (WIDTH_W'(oc_e) == w - WIDTH_W'(1));
    ctrl.use_mid   = (HEIGHT_W'(out_row) >= h - HEIGHT_W'(1));
    ctrl.rd_addr   = is_flush ? out_column : in_column;
    ctrl.ctr_addr  = (in_column == '0) ? COL_W'(w - WIDTH_W'(1))
                                       : in_column - COL_W'(1);
    ctrl.wr_addr   = in_column;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
      in_column    <= '0;
      in_row       <= '0;
      out_column   <= '0;
      out_row      <= '0;
      pending      <= '0;
    end else begin
      if (cfg_write_en) begin
        if (cfg_reg_t'(cfg_index) == REG_FRAME_WIDTH) begin
          frame_width <= cfg_data[WIDTH_W-1:0];
        end else begin
          frame_height <= cfg_data[HEIGHT_W-1:0];
        end
      end
      in_column  <= in_column_next;
      in_row     <= in_row_next;
      out_column <= out_column_next;
      out_row    <= out_row_next;
      pending    <= pending_next;
    end
  end

endmodule

### src/bf3_lines.sv
// ----------------------------------------------------------------------------
// bf3_lines: upper and middle line stores
// Registered reads with bypass of the write that lands in the same cycle.
// ----------------------------------------------------------------------------
module bf3_lines (
  input  logic                       clk,
  input  logic                       en,
  input  logic [bf3_pkg::COL_W-1:0]  rd_addr,
  input  logic [bf3_pkg::COL_W-1:0]  ctr_addr,
  input  logic                       wr_en,
  input  logic [bf3_pkg::COL_W-1:0]  wr_addr,
  input  bf3_pkg::bgr_t              wr_up,
  input  bf3_pkg::bgr_t              wr_mid,
  output bf3_pkg::bgr_t              up,
  output bf3_pkg::bgr_t              ctr,
  output bf3_pkg::bgr_t              mid
);
  import bf3_pkg::*;

  bgr_t upper_mem [MAX_WIDTH];
  bgr_t middle_mem [MAX_WIDTH];

  bgr_t up_raw, ctr_raw, mid_raw;
  bgr_t up_byp, mid_byp;
  logic up_fwd, ctr_fwd, mid_fwd;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      upper_mem[wr_addr] <= wr_up;
    end
    if (en) begin
      up_raw  <= upper_mem[rd_addr];
      ctr_raw <= upper_mem[ctr_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      middle_mem[wr_addr] <= wr_mid;
    end
    if (en) begin
      mid_raw <= middle_mem[rd_addr];
    end
  end

  // Capture the write that the array misses on this read.
  always_ff @(posedge clk) begin
    if (en) begin
      up_fwd  <= wr_en && (wr_addr == rd_addr);
      ctr_fwd <= wr_en && (wr_addr == ctr_addr);
      mid_fwd <= wr_en && (wr_addr == rd_addr);
      up_byp  <= wr_up;
      mid_byp <= wr_mid;
    end
  end

  assign up  = up_fwd  ? up_byp  : up_raw;
  assign ctr = ctr_fwd ? up_byp  : ctr_raw;
  assign mid = mid_fwd ? mid_byp : mid_raw;

endmodule

### src/bf3_lane.sv
// ----------------------------------------------------------------------------
// bf3_lane: one color channel of the filter
// Holds the 3x3 window of its channel and computes the rounded mean.
// ----------------------------------------------------------------------------
module bf3_lane (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        shift,
  input  logic [bf3_pkg::CHAN_W-1:0]  up,
  input  logic [bf3_pkg::CHAN_W-1:0]  mid,
  input  logic [bf3_pkg::CHAN_W-1:0]  pix,
  output logic [bf3_pkg::CHAN_W-1:0]  mean
);
  import bf3_pkg::*;

  logic [2:0][2:0][CHAN_W-1:0] win;
  logic [SUM_W-1:0]            sum, sum_q;
  logic [PROD_W-1:0]           prod_q;

  // Shift left by one column, new column enters on the right.
  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (shift) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= up;
      win[1][2] <= mid;
      win[2][2] <= pix;
    end
  end

  always_comb begin
    sum = ROUND_BIAS;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        sum = sum + SUM_W'(win[r][c]);
      end
    end
  end

  // Divide by nine through the reciprocal.
  always_ff @(posedge clk) begin
    if (en) begin
      sum_q  <= sum;
      prod_q <= PROD_W'(sum_q) * PROD_W'(RECIP_NINE);
    end
  end

  assign mean = prod_q[RECIP_SHIFT +: CHAN_W];

endmodule

### src/box_filter_3x3_rgb.sv
// ----------------------------------------------------------------------------
// box_filter_3x3_rgb: 3x3 rounded-mean filter on a BGR raster stream
//
// Pixels enter on the pixel channel in raster order (command = pixel) and
// leave on the result channel; every transfer is taken when valid is high
// and stall is low. A pixel comes out frame_width + 1 input transfers after
// it went in; interior pixels are replaced per channel by (sum + 4) / 9 of
// their 3x3 neighborhood, border rows and columns pass unchanged, and
// frame_end marks the bottom-right pixel. After the last pixel of a frame,
// flush transfers drain the pending pixels one each; a flush at any other
// time produces nothing.
// Throughput is one transfer per clock while no result is held by a stall.
// The result of a transfer passes the line store read, registered on the
// transfer edge, then the window update, the per-channel sum and the
// reciprocal multiply, and the output register.
// A stalled result holds the whole pipeline and raises pixel_stall in the
// same cycle; nothing is dropped.
// Reset (rst, synchronous) restores 640 x 480, clears positions, pending
// count and windows; line stores are not cleared and need no clearing pass.
// Geometry registers are written through cfg_write_en / cfg_index / cfg_data
// by the user, only while the stream is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module box_filter_3x3_rgb (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write_en,
  input  logic [bf3_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [bf3_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             pixel_valid,
  output logic                             pixel_stall,
  input  bf3_pkg::pixel_in_t               pixel,
  output logic                             result_valid,
  input  logic                             result_stall,
  output bf3_pkg::pixel_out_t              result
);
  import bf3_pkg::*;

  logic  en;
  logic  take;
  logic  shift;
  ctrl_t ctrl;
  ctrl_t s1_next;
  ctrl_t s1;
  bgr_t  s1_pix;
  bgr_t  pix_in;
  bgr_t  up, ctr, mid;
  tag_t  s2, s3, s4;
  bgr_t  mean;
  bgr_t  merged;

  // The pipeline moves as one unit unless a finished result is held.
  assign en          = !(result_valid && result_stall);
  assign pixel_stall = !en;
  assign take        = pixel_valid && en;

  assign pix_in[LANE_BLUE]  = pixel.blue_in;
  assign pix_in[LANE_GREEN] = pixel.green_in;
  assign pix_in[LANE_RED]   = pixel.red_in;

  bf3_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .take         (take),
    .command      (pixel.command),
    .ctrl         (ctrl)
  );

  // Stage 1: the transfer's decision waits for the line store read.
  always_comb begin
    s1_next       = ctrl;
    s1_next.valid = take && ctrl.valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
    end else if (en) begin
      s1 <= s1_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pix <= pix_in;
    end
  end

  // Pixel transfers push the column into the window and the line stores.
  assign shift = en && s1.valid && s1.pixel;

  bf3_lines u_lines (
    .clk      (clk),
    .en       (en),
    .rd_addr  (ctrl.rd_addr),
    .ctr_addr (ctrl.ctr_addr),
    .wr_en    (shift),
    .wr_addr  (s1.wr_addr),
    .wr_up    (mid),
    .wr_mid   (s1_pix),
    .up       (up),
    .ctr      (ctr),
    .mid      (mid)
  );

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    bf3_lane u_lane (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .shift (shift),
      .up    (up[i]),
      .mid   (mid[i]),
      .pix   (s1_pix[i]),
      .mean  (mean[i])
    );
  end

  // Stages 2 to 4: side information aligned with the lane pipelines.
  // Flushes pass the stored pixel of the output row; pixels pass the center.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2 <= '0;
      s3 <= '0;
      s4 <= '0;
    end else if (en) begin
      s2.emit      <= s1.valid && s1.emit;
      s2.interior  <= s1.interior;
      s2.frame_end <= s1.frame_end;
      s2.pass      <= s1.pixel ? ctr : (s1.use_mid ? mid : up);
      s3.emit      <= s2.emit;
      s3.interior  <= s2.interior;
      s3.frame_end <= s2.frame_end;
      s3.pass      <= s2.pass;
      s4.emit      <= s3.emit;
      s4.interior  <= s3.interior;
      s4.frame_end <= s3.frame_end;
      s4.pass      <= s3.pass;
    end
  end

  // Merge: take each lane's mean for interior pixels, else pass through.
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      merged[i] = s4.interior ? mean[i] : s4.pass[i];
    end
  end

  // Output register; hold while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= s4.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.blue_out  <= merged[LANE_BLUE];
      result.green_out <= merged[LANE_GREEN];
      result.red_out   <= merged[LANE_RED];
      result.frame_end <= s4.frame_end;
    end
  end

  // An interior pixel is never the bottom-right pixel of a frame.
  a_interior_not_end: assert property (@(posedge clk) disable iff (rst)
    s4.emit && s4.interior |-> !s4.frame_end)
    else $error("interior pixel flagged as frame end");

  // A flush that reaches stage 1 always emits and always passes through.
  a_flush_pass: assert property (@(posedge clk) disable iff (rst)
    s1.valid && !s1.pixel |-> s1.emit && !s1.interior)
    else $error("flush transfer not emitted as pass-through");

  // A result leaving the last stage lands in the output register.
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    en && s4.emit |=> result_valid)
    else $error("result lost between last stage and output register");

  // The line stores are written only when the pipeline advances.
  a_write_moves: assert property (@(posedge clk) disable iff (rst)
    shift |-> !(result_valid && result_stall))
    else $error("line store written during a stall");

endmodule
